@@ rtl/core/assert_macros.svh @@
// Assertion macros for the alias region table RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

@@ rtl/core/arp_pkg.sv @@
// Package for the alias region table: sizes, operation and status codes,
// controller states and the structs passed along the slot chain.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

	localparam int REGIONS = 64;
	localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam logic [8:0] SLOT_LIM = 9'(REGIONS);

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_CONNECT = 2'd0,
		OP_DELETE  = 2'd1,
		OP_CHECK   = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_CLOSED      = 3'd1,
		ST_ALIAS_ZERO  = 3'd2,
		ST_WRONG_INDEX = 3'd3,
		ST_NOT_INIT    = 3'd4,
		ST_FULL        = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_DONE = 2'd2
	} state_t;

	// Search token that walks the slot chain, one cell per cycle
	typedef struct packed {
		logic       active;
		logic [7:0] alias_key;
		logic [7:0] slot;
		logic       hit;
		idx_t       hit_at;
		logic       free;
		idx_t       free_at;
		logic       sel_valid;
	} token_t;

	// Table update broadcast from the controller to every cell
	typedef struct packed {
		logic       set;
		logic       clr;
		logic       clear_all;
		idx_t       idx;
		logic [7:0] alias_key;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/arp_cell.sv @@
// One slot of the alias region table: valid bit, alias and a token stage.
// Depends on arp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arp_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire arp_pkg::idx_t   my_idx,
	input  wire arp_pkg::token_t tok_in,
	output arp_pkg::token_t      tok_out,
	input  wire arp_pkg::cmd_t   cmd
);
	import arp_pkg::*;

	logic       valid_q;
	logic [7:0] alias_q;
	token_t     tok_q;
	token_t     tok_nxt;

	// Fold this slot into the passing token
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.active) begin
			if (!tok_in.hit && valid_q && (alias_q == tok_in.alias_key)) begin
				tok_nxt.hit    = 1'b1;
				tok_nxt.hit_at = my_idx;
			end
			if (!tok_in.free && !valid_q) begin
				tok_nxt.free    = 1'b1;
				tok_nxt.free_at = my_idx;
			end
			if (tok_in.slot == 8'(my_idx)) begin
				tok_nxt.sel_valid = valid_q;
			end
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	// Apply table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			alias_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= 1'b0;
			alias_q <= '0;
		end else if (cmd.idx == my_idx) begin
			if (cmd.set) begin
				valid_q <= 1'b1;
				alias_q <= cmd.alias_key;
			end else if (cmd.clr) begin
				valid_q <= 1'b0;
				alias_q <= '0;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

@@ rtl/core/arp_ctrl.sv @@
// Request controller: launches a search token, decides the outcome when it
// returns, broadcasts the table update and holds the result word.
// Depends on arp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module arp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire arp_pkg::op_t     req_op,
	input  wire logic [7:0]       req_alias,
	input  wire logic [7:0]       req_slot,
	output arp_pkg::token_t       tok_first,
	input  wire arp_pkg::token_t  tok_last,
	output arp_pkg::cmd_t         cmd,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [5:0]            region_slot,
	output arp_pkg::status_t      status,
	output logic                  reused
);
	import arp_pkg::*;

	state_t     state_q, state_nxt;
	logic       launch_q;
	op_t        op_q;
	logic [7:0] alias_q;
	logic [7:0] slot_q;
	token_t     res_q;
	logic       load;
	logic       in_range;

	cmd_t       dec_cmd;
	status_t    dec_status;
	logic [5:0] dec_slot;
	logic       dec_reused;

	logic       out_valid_q;
	logic [5:0] out_slot_q;
	status_t    out_status_q;
	logic       out_reused_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_range = ({1'b0, slot_q} < SLOT_LIM);

	// Hold the request and pulse the token launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
		end else begin
			launch_q <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= req_op;
			alias_q <= req_alias;
			slot_q  <= req_slot;
		end
		if (state_q == S_SCAN && tok_last.active) begin
			res_q <= tok_last;
		end
	end

	// Fresh token into the first cell
	always_comb begin
		tok_first           = '0;
		tok_first.active    = launch_q;
		tok_first.alias_key = alias_q;
		tok_first.slot      = slot_q;
	end

	// Decide the outcome from the returned token
	always_comb begin
		dec_cmd           = '0;
		dec_cmd.alias_key = alias_q;
		dec_status        = ST_OK;
		dec_slot          = '0;
		dec_reused        = 1'b0;
		case (op_q)
			OP_CONNECT: begin
				if (alias_q == 8'd0) begin
					dec_status = ST_ALIAS_ZERO;
				end else if (res_q.hit) begin
					dec_slot   = 6'(res_q.hit_at);
					dec_reused = 1'b1;
				end else if (res_q.free) begin
					dec_slot    = 6'(res_q.free_at);
					dec_cmd.set = 1'b1;
					dec_cmd.idx = res_q.free_at;
				end else begin
					dec_status = ST_FULL;
				end
			end
			OP_DELETE: begin
				if (!in_range) begin
					dec_status = ST_WRONG_INDEX;
				end else if (!res_q.sel_valid) begin
					dec_status = ST_NOT_INIT;
				end else begin
					dec_cmd.clr = 1'b1;
					dec_cmd.idx = slot_q[IDX_W-1:0];
				end
			end
			OP_CHECK: begin
				if (!in_range || !res_q.sel_valid) begin
					dec_status = ST_CLOSED;
				end
			end
			OP_CLEAR: begin
				dec_cmd.clear_all = 1'b1;
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, commit and result load
	always_comb begin
		state_nxt = state_q;
		load      = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (tok_last.active) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load      = 1'b1;
					cmd       = dec_cmd;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_slot_q   <= dec_slot;
			out_status_q <= dec_status;
			out_reused_q <= dec_reused;
		end
	end

	assign out_valid   = out_valid_q;
	assign region_slot = out_slot_q;
	assign status      = out_status_q;
	assign reused      = out_reused_q;

	`ASSERT_CLK(a_tok_in_scan, clk, arst_n, tok_last.active |-> (state_q == S_SCAN), "token returned outside a scan")
	`ASSERT_NEVER(a_cmd_no_load, clk, arst_n, (cmd.set || cmd.clr || cmd.clear_all) && !load, "table update without a result")
	`ASSERT_CLK(a_accept_scan, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_SCAN && launch_q), "accepted word did not launch a scan")
	`ASSERT_NEVER(a_set_hit, clk, arst_n, cmd.set && res_q.hit, "slot claimed although the alias was found")

endmodule

`default_nettype wire

@@ rtl/core/alias_region_table.sv @@
// Top level of the alias region table: controller plus a chain of slot cells.
// Depends on arp_pkg, arp_cell and arp_ctrl.
//
//   channel  dir  tdata                              tuser
//   s_*      in   [7:0] alias_req, [15:8] slot       [1:0] operation
//   m_*      out  [5:0] region_slot, [7:6] zero      [2:0] status, [3] reused
//
// m_tvalid rises once the search token has walked the slot chain, one cell per cycle, the
// controller has latched the returned token in S_SCAN and, in S_DONE, has decided, committed
// and loaded the result word. With m_tready high, s_tready is high again in the same cycle
// as m_tvalid rises. s_tready is high only when the block is idle; a result held by a stalled
// m_tready blocks only the commit of the next word.
// Reset empties the table at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module alias_region_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [7:0] alias_req, [15:8] slot
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [5:0] region_slot, [7:6] zero
	output logic [3:0]       m_tuser   // [2:0] status, [3] reused
);
	import arp_pkg::*;

	token_t     tok [REGIONS+1];
	cmd_t       cmd;
	op_t        req_op;
	status_t    status;
	logic [5:0] region_slot;
	logic       reused;

	assign req_op = op_t'(s_tuser);

	arp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.req_op      (req_op),
		.req_alias   (s_tdata[7:0]),
		.req_slot    (s_tdata[15:8]),
		.tok_first   (tok[0]),
		.tok_last    (tok[REGIONS]),
		.cmd         (cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.region_slot (region_slot),
		.status      (status),
		.reused      (reused)
	);

	// Chain of slot cells, token moves one cell per cycle
	for (genvar g = 0; g < REGIONS; g++) begin : g_cell
		arp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (IDX_W'(g)),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.cmd     (cmd)
		);
	end

	assign m_tdata = {2'b00, region_slot};
	assign m_tuser = {reused, status};

endmodule

`default_nettype wire
